@@ rtl/pbtw_pkg.sv @@
// Package for per-id busy-time window accounting.
// Types and constants shared by the slot cell, close unit and top level.
`timescale 1ns / 1ps
package pbtw_pkg;
  localparam int SLOTS_DEF = 64;
  localparam int OWNER_W = 32;
  localparam int TIME_W = 64;
  localparam int TICK_W = 34;
  localparam int WIN_W = 30;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 30'd1000000000;
  // ns = ticks * 1e9 / 19.2e6 = ticks * 625 / 12
  // ticks / 12 = (ticks / 4) / 3, the divide by 3 by reciprocal multiply
  localparam int NS_MUL = 625;
  localparam logic [31:0] DIV3_RECIP = 32'hAAAAAAAB;
  localparam logic [0:0] CFG_ENABLE = 1'b0;
  localparam logic [0:0] CFG_WINDOW = 1'b1;
  localparam logic OP_ACCOUNT = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic                 used;
    logic [OWNER_W-1:0]   owner;
    logic [TIME_W-1:0]    wopen;
    logic [TIME_W-1:0]    wlast;
    logic [TIME_W-1:0]    busy;
    logic [TIME_W-1:0]    pend;
  } slot_t;
endpackage

@@ rtl/pbtw_cell.sv @@
// One slot cell of the rotating slot ring.
// Depends on pbtw_pkg.
`timescale 1ns / 1ps
module pbtw_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  pbtw_pkg::slot_t d,
  output pbtw_pkg::slot_t q
);
  import pbtw_pkg::*;
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end
endmodule

@@ rtl/pbtw_close.sv @@
// Period close arithmetic for the slot at the head of the ring.
// Depends on pbtw_pkg; purely combinational, one compare chain.
`timescale 1ns / 1ps
module pbtw_close (
  input  pbtw_pkg::slot_t s,
  input  logic [pbtw_pkg::WIN_W-1:0] win,
  output logic made,
  output logic [pbtw_pkg::TIME_W-1:0] start,
  output logic [pbtw_pkg::WIN_W-1:0] busy_o
);
  import pbtw_pkg::*;
  logic [TIME_W-1:0] w64, b, per, st, len;
  always_comb begin
    w64 = {{(TIME_W-WIN_W){1'b0}}, win};
    b = (s.busy > w64) ? w64 : s.busy;
    per = s.wlast - s.wopen;
    if (per < b) per = b;
    if (per > w64) per = w64;
    st = s.wlast - per;
    if (st < s.pend) st = s.pend;
    len = s.wlast - st;
    if (b > len) b = len;
    made = (s.busy != '0) && (st < s.wlast) && (b != '0);
    start = st;
    busy_o = b[WIN_W-1:0];
  end
endmodule

@@ rtl/per_id_busy_time_window_accounting.sv @@
// Top level: slot ring of cells, tick conversion and sequencer.
// Depends on pbtw_pkg, pbtw_cell and pbtw_close.
//
// channel | dir | handshake      | content
// s_axis  | in  | tvalid/tready  | op in tuser, owner/ticks/now in tdata
// m_axis  | out | tvalid/tready  | owner/start/end/busy in tdata, last in tlast
// cfg     | in  | valid/ready    | index, data
// An account transfer is done before the next is taken: ST_CONV and ST_NS
// convert ticks, one ring rotation finds the slot, one more updates it.
// A flush is one ring rotation; the held last period is handed out in ST_IDLE.
// Output stalls hold the ring in place. Reset clears all slots at once.
`timescale 1ns / 1ps
module per_id_busy_time_window_accounting #(
  parameter int SLOTS = pbtw_pkg::SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [135:0] s_axis_tdata, // owner_id, busy_ticks, now_ns
  input  logic [0:0] s_axis_tuser,   // op
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [191:0] m_axis_tdata, // period_owner, period_start, period_end, period_busy
  output logic m_axis_tlast,         // last
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import pbtw_pkg::*;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [2:0] ST_IDLE = 3'd0, ST_CONV = 3'd1, ST_SCAN = 3'd2,
                         ST_UPD = 3'd3, ST_FLUSH = 3'd4, ST_NS = 3'd5;
  logic [2:0] state;
  logic enable;
  logic [WIN_W-1:0] win;
  logic [OWNER_W-1:0] owner;
  logic [TIME_W-1:0] now, ns, recip;
  logic [TICK_W-1:0] ticks;
  logic [30:0] quo;
  logic [3:0] rem;
  logic [CW-1:0] cnt;
  logic found, idle_ok;
  logic [CW-1:0] hit, idx;
  slot_t ring [SLOTS];
  slot_t head_next;
  logic shift;
  logic made, em;
  logic [TIME_W-1:0] cstart;
  logic [WIN_W-1:0] cbusy;
  logic pending;  // emitted period held back to learn last

  function automatic logic [9:0] rem_ns(input logic [3:0] r);
    case (r)
      4'd0: rem_ns = 10'd0;
      4'd1: rem_ns = 10'd52;
      4'd2: rem_ns = 10'd104;
      4'd3: rem_ns = 10'd156;
      4'd4: rem_ns = 10'd208;
      4'd5: rem_ns = 10'd260;
      4'd6: rem_ns = 10'd312;
      4'd7: rem_ns = 10'd364;
      4'd8: rem_ns = 10'd416;
      4'd9: rem_ns = 10'd468;
      4'd10: rem_ns = 10'd520;
      4'd11: rem_ns = 10'd572;
      default: rem_ns = 10'd0;
    endcase
  endfunction

  genvar g;
  for (g = 0; g < SLOTS; g++) begin : g_ring
    if (g == SLOTS-1) begin : g_tail
      pbtw_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d(head_next), .q(ring[g]));
    end else begin : g_body
      pbtw_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d(ring[g+1]), .q(ring[g]));
    end
  end

  pbtw_close u_close (.s(ring[0]), .win(win), .made(made), .start(cstart),
    .busy_o(cbusy));

  assign s_axis_tready = (state == ST_IDLE) && !pending;
  assign cfg_ready = (state == ST_IDLE);
  logic outfree;
  assign outfree = !m_axis_tvalid || m_axis_tready;

  assign recip = TIME_W'(ticks[TICK_W-1:2]) * TIME_W'(DIV3_RECIP);
  assign rem = 4'(ticks[3:0] - {quo[0], 3'b000} - {quo[1:0], 2'b00});

  // account update on the head slot during the update pass when it is the target
  logic tgt, do_close;
  logic [TIME_W-1:0] wo;
  slot_t upd;
  always_comb begin
    tgt = (state == ST_UPD) && (idx == hit);
    upd = ring[0];
    if (tgt) begin
      if (!found) begin
        upd = '0; upd.used = 1'b1; upd.owner = owner;
      end
      wo = (upd.wopen == '0) ? now : upd.wopen;
      upd.wopen = wo; upd.wlast = now; upd.busy = upd.busy + ns;
    end else begin
      wo = '0;
    end
    do_close = tgt && ((now - wo) >= {{(TIME_W-WIN_W){1'b0}}, win});
  end

  // period record for the slot being closed, computed from the update
  slot_t csrc;
  logic cm;
  logic [TIME_W-1:0] cst;
  logic [WIN_W-1:0] cb;
  pbtw_close u_close2 (.s(csrc), .win(win), .made(cm), .start(cst), .busy_o(cb));
  assign csrc = upd;

  logic fl_act;
  assign fl_act = (state == ST_FLUSH) && ring[0].used && (ring[0].busy != '0);
  assign em = (fl_act && made) || (do_close && cm);

  always_comb begin
    head_next = ring[0];
    if (state == ST_UPD) head_next = upd;
    if (fl_act || do_close) begin
      head_next = (state == ST_UPD) ? upd : ring[0];
      if (em) head_next.pend = head_next.wlast;
      head_next.wopen = '0; head_next.wlast = '0; head_next.busy = '0;
    end
  end

  assign shift = ((state == ST_SCAN) || (state == ST_UPD) || (state == ST_FLUSH))
                 && (!em || !pending || outfree);

  logic load_mid, load_end;
  assign load_mid = ((state == ST_UPD) || (state == ST_FLUSH)) && shift && em && pending;
  assign load_end = (state == ST_IDLE) && pending && outfree;

  logic [191:0] hold;
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; enable <= 1'b0; win <= WINDOW_RESET;
      m_axis_tvalid <= 1'b0; pending <= 1'b0;
    end else begin
      if (load_mid || load_end) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == CFG_ENABLE) enable <= cfg_data[0];
            else win <= cfg_data[WIN_W-1:0];
          end
          if (s_axis_tvalid && s_axis_tready) begin
            owner <= s_axis_tdata[31:0];
            ticks <= s_axis_tdata[65:32];
            now <= s_axis_tdata[129:66];
            cnt <= '0; found <= 1'b0; idle_ok <= 1'b0;
            state <= (s_axis_tuser[0] == OP_FLUSH) ? ST_FLUSH : ST_CONV;
            idx <= '0;
          end
        end
        ST_CONV: begin
          quo <= recip[63:33];
          state <= ST_NS;
        end
        ST_NS: begin
          ns <= TIME_W'(quo) * TIME_W'(NS_MUL) + TIME_W'(rem_ns(rem));
          state <= (ticks == '0 || !enable) ? ST_IDLE : ST_SCAN;
        end
        ST_SCAN: begin
          if (!found) begin
            if (ring[0].used && ring[0].owner == owner) begin
              found <= 1'b1; hit <= cnt;
            end else if (!idle_ok && (!ring[0].used || ring[0].busy == '0)) begin
              idle_ok <= 1'b1; hit <= cnt;
            end
          end
          cnt <= cnt + 1'b1;
          if (cnt == CW'(SLOTS-1)) begin
            state <= ((found || idle_ok || (ring[0].used && ring[0].owner == owner)
                      || !ring[0].used || ring[0].busy == '0)) ? ST_UPD : ST_IDLE;
            idx <= '0;
          end
        end
        ST_UPD, ST_FLUSH: begin
          if (shift) begin
            if (em) begin
              if (pending) begin
                m_axis_tdata <= hold; m_axis_tlast <= 1'b0;
              end
              pending <= 1'b1;
              hold <= {2'd0, (state == ST_UPD) ? cb : cbusy, upd.wlast,
                       (state == ST_UPD) ? cst : cstart, upd.owner};
            end
            idx <= idx + 1'b1;
            if (idx == CW'(SLOTS-1)) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (load_end) begin
        m_axis_tdata <= hold; m_axis_tlast <= 1'b1;
        pending <= 1'b0;
      end
    end
  end

  a_idle_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (state != ST_IDLE)) else $error("accept");
  a_no_out_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !pending) else $error("pending");
  a_win: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD) |-> (found || idle_ok)) else $error("target");
endmodule

@@ tb/sv/pbtw_checker.sv @@
// Checker for per-id busy-time window accounting: watches the config, input
// and period channels, predicts the periods and compares them in order.
// Depends on pbtw_pkg.
`timescale 1ns / 1ps
module pbtw_checker #(
  parameter int SLOTS = pbtw_pkg::SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  input  logic s_axis_tready,
  input  logic [135:0] s_axis_tdata,
  input  logic [0:0] s_axis_tuser,
  input  logic m_axis_tvalid,
  input  logic m_axis_tready,
  input  logic [191:0] m_axis_tdata,
  input  logic m_axis_tlast,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [31:0] cfg_data,
  output int fails,
  output int pending
);
  import pbtw_pkg::*;

  typedef struct {
    logic [OWNER_W-1:0] owner;
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] stop;
    logic [WIN_W-1:0] busy;
    logic last;
  } period_t;

  period_t period_q[$];
  logic used_r[SLOTS];
  logic [OWNER_W-1:0] owner_r[SLOTS];
  logic [TIME_W-1:0] open_r[SLOTS];
  logic [TIME_W-1:0] act_r[SLOTS];
  logic [TIME_W-1:0] busy_r[SLOTS];
  logic [TIME_W-1:0] pend_r[SLOTS];
  logic en_r;
  logic [WIN_W-1:0] win_r;

  function automatic int close_window(int s);
    logic [TIME_W-1:0] st, en, bz, per, win;
    period_t p;
    int made;
    made = 0;
    win = {{(TIME_W-WIN_W){1'b0}}, win_r};
    if (busy_r[s] != 0) begin
      en = act_r[s];
      bz = busy_r[s];
      if (bz > win) bz = win;
      per = act_r[s] - open_r[s];
      if (per < bz) per = bz;
      if (per > win) per = win;
      st = en - per;
      if (st < pend_r[s]) st = pend_r[s];
      if (st < en) begin
        if (bz > en - st) bz = en - st;
        if (bz != 0) begin
          p.owner = owner_r[s];
          p.start = st;
          p.stop = en;
          p.busy = bz[WIN_W-1:0];
          p.last = 1'b0;
          period_q.push_back(p);
          pend_r[s] = en;
          made = 1;
        end
      end
    end
    open_r[s] = '0;
    act_r[s] = '0;
    busy_r[s] = '0;
    return made;
  endfunction

  task automatic predict_item(logic op, logic [31:0] own, logic [33:0] ticks,
                              logic [63:0] now);
    int made, s, idle;
    logic [63:0] ns;
    made = 0;
    s = -1;
    idle = -1;
    if (op == OP_FLUSH) begin
      for (int i = 0; i < SLOTS; i++)
        if (used_r[i] && busy_r[i] != 0) made += close_window(i);
    end else begin
      ns = {30'b0, ticks} * 64'd1000000000 / 64'd19200000;
      if (!en_r || ns == 0) return;
      for (int i = 0; i < SLOTS; i++) begin
        if (s < 0 && used_r[i] && owner_r[i] == own) s = i;
        if (s < 0 && idle < 0 && (!used_r[i] || busy_r[i] == 0)) idle = i;
      end
      if (s < 0) begin
        if (idle < 0) return;
        s = idle;
        used_r[s] = 1'b1;
        owner_r[s] = own;
        open_r[s] = '0;
        act_r[s] = '0;
        busy_r[s] = '0;
        pend_r[s] = '0;
      end
      if (open_r[s] == 0) open_r[s] = now;
      act_r[s] = now;
      busy_r[s] = busy_r[s] + ns;
      if (now - open_r[s] >= {34'b0, win_r}) made = close_window(s);
    end
    if (made > 0) period_q[period_q.size()-1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    period_t e;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        used_r[i] = 1'b0;
        owner_r[i] = '0;
        open_r[i] = '0;
        act_r[i] = '0;
        busy_r[i] = '0;
        pend_r[i] = '0;
      end
      en_r = 1'b0;
      win_r = WINDOW_RESET;
      period_q.delete();
      fails = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (period_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected period transfer: %h", m_axis_tdata);
        end else begin
          e = period_q.pop_front();
          if (m_axis_tdata[31:0] !== e.owner || m_axis_tdata[95:32] !== e.start ||
              m_axis_tdata[159:96] !== e.stop || m_axis_tdata[189:160] !== e.busy ||
              m_axis_tdata[191:190] !== 2'b00 || m_axis_tlast !== e.last) begin
            fails++;
            if (fails <= 10)
              $display("period mismatch: exp own %h st %h end %h busy %h last %b",
                       e.owner, e.start, e.stop, e.busy, e.last,
                       " / got own %h st %h end %h busy %h last %b",
                       m_axis_tdata[31:0], m_axis_tdata[95:32], m_axis_tdata[159:96],
                       m_axis_tdata[189:160], m_axis_tlast);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ENABLE) en_r = cfg_data[0];
        else win_r = cfg_data[WIN_W-1:0];
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_item(s_axis_tuser[0], s_axis_tdata[31:0], s_axis_tdata[65:32],
                     s_axis_tdata[129:66]);
    end
    pending = period_q.size();
  end
endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top for per_id_busy_time_window_accounting: clock, reset,
// stimulus with random idling and back-pressure, and the verdict.
// Depends on pbtw_pkg, pbtw_checker and the block itself.
`timescale 1ns / 1ps
module tb_top;
  import pbtw_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [191:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int fails, pending;
  logic calm = 1'b0;
  logic hold_req = 1'b0;
  logic held = 1'b0;
  logic [63:0] clock_ns;
  int pool;

  per_id_busy_time_window_accounting DUT (.*);
  pbtw_checker CHK (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: random stalls, one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !held) begin
      held = 1'b1;
      m_axis_tready = 1'b0;
      repeat (1500) @(negedge clk);
    end
    m_axis_tready = calm || ($urandom_range(99) >= 24);
  end

  task automatic send(logic op, logic [31:0] own, logic [33:0] ticks, logic [63:0] now);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 24) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = op;
    s_axis_tdata = {6'd0, now, ticks, own};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic settle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    wait (pending == 0);
    repeat (SLOTS_DEF + 80) @(negedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    settle();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [33:0] pick_ticks();
    case ($urandom_range(9))
      0: return '0;
      1: return 34'd1;
      2: return 34'h3FFFFFFFF;
      3: return 34'({$urandom, $urandom});
      default: return 34'($urandom_range(4000, 1));
    endcase
  endfunction

  // mostly a steady clock of activity; some noise in owner and time
  task automatic random_items(int count, int span);
    logic [31:0] own;
    logic [63:0] now;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 8) begin
        send(OP_FLUSH, $urandom, pick_ticks(), {$urandom, $urandom});
      end else begin
        clock_ns = clock_ns + $urandom_range(span);
        own = 32'h100 + $urandom_range(pool - 1);
        now = clock_ns;
        if ($urandom_range(99) < 6) own = $urandom;
        if ($urandom_range(99) < 6) now = {$urandom, $urandom};
        send(OP_ACCOUNT, own, pick_ticks(), now);
      end
    end
  endtask

  initial begin
    clock_ns = 64'd5000;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send(OP_ACCOUNT, 32'd1, 34'd500, 64'd50);
    write_reg(CFG_ENABLE, 32'd1);
    write_reg(CFG_WINDOW, 32'd1000);
    send(OP_ACCOUNT, 32'd0, 34'd0, 64'd5);
    send(OP_FLUSH, 32'd0, 34'd0, 64'd0);
    send(OP_ACCOUNT, 32'hFFFFFFFF, 34'd1, 64'd100);
    send(OP_ACCOUNT, 32'hFFFFFFFF, 34'd20, 64'd2000);
    send(OP_ACCOUNT, 32'hFFFFFFFF, 34'd30, 64'd2500);
    send(OP_ACCOUNT, 32'd7, 34'd40, 64'd0);
    send(OP_ACCOUNT, 32'd7, 34'd40, 64'd300);
    send(OP_FLUSH, 32'd0, 34'd0, 64'd0);
    send(OP_ACCOUNT, 32'd5, 34'h3FFFFFFFF, 64'hFFFFFFFFFFFFFFF0);
    send(OP_ACCOUNT, 32'd5, 34'd100, 64'd10);
    send(OP_ACCOUNT, 32'd9, 34'd3000, 64'd1200);
    send(OP_ACCOUNT, 32'd9, 34'd10, 64'd1150);
    send(OP_FLUSH, 32'hFFFFFFFF, 34'h3FFFFFFFF, 64'hFFFFFFFFFFFFFFFF);

    // long receiver hold-off while items keep coming
    @(negedge clk);
    hold_req = 1'b1;
    pool = 6;
    random_items(20, 600);
    settle();
    calm = 1'b1;
    random_items(10, 600);
    calm = 1'b0;
    random_items(10, 600);

    write_reg(CFG_WINDOW, 32'd1000000000);
    pool = 70;
    random_items(30, 30000000);
    send(OP_FLUSH, 32'd0, 34'd0, 64'd0);

    write_reg(CFG_WINDOW, 32'd1);
    write_reg(CFG_ENABLE, 32'd0);
    pool = 4;
    random_items(5, 3);
    write_reg(CFG_ENABLE, 32'd1);
    random_items(15, 3);
    send(OP_FLUSH, 32'd0, 34'd0, 64'd0);

    write_reg(CFG_WINDOW, 32'd50000);
    pool = 10;
    random_items(15, 20000);
    send(OP_FLUSH, 32'd0, 34'd0, 64'd0);

    settle();
    repeat (200) @(posedge clk);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
